/* rtl/core/etsc_pkg.sv */
// ----------------------------------------------------------------------------
// Expression token syntax checker package
// Token class and verdict codes that the checker uses.
// ----------------------------------------------------------------------------
package etsc_pkg;

   localparam int unsigned ClassWidth   = 3;
   localparam int unsigned VerdictWidth = 3;
   localparam int unsigned IndexWidth   = 10;

   // One code beyond the three-bit input range marks "past the end".
   typedef enum logic [ClassWidth:0] {
      CLS_VALUE    = 4'd0,
      CLS_UNARY    = 4'd1,
      CLS_OPER     = 4'd2,
      CLS_OPEN     = 4'd3,
      CLS_CLOSE    = 4'd4,
      CLS_COMMA    = 4'd5,
      CLS_UNLISTED = 4'd6,
      CLS_OTHER    = 4'd7,
      CLS_NONE     = 4'd8
   } tok_class_type;

   typedef enum logic [VerdictWidth-1:0] {
      VRD_OK      = 3'd0,
      VRD_START   = 3'd1,
      VRD_OPER    = 3'd2,
      VRD_VALUE   = 3'd3,
      VRD_STRAY   = 3'd4,
      VRD_MISSING = 3'd5,
      VRD_DEPTH   = 3'd6
   } verdict_type;

endpackage

/* rtl/core/etsc_if.sv */
// ----------------------------------------------------------------------------
// Expression token syntax checker channels
// Valid/ready channels for the token stream and for the verdict.
// ----------------------------------------------------------------------------
interface etsc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_class;
   logic       first_token;
   logic       last_token;
   logic       call_mode;

   modport source (output valid, token_class, first_token, last_token, call_mode,
                   input ready);
   modport sink (input valid, token_class, first_token, last_token, call_mode,
                 output ready);
endinterface

interface etsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic [9:0] error_index;

   modport source (output valid, verdict, error_index, input ready);
   modport sink (input valid, verdict, error_index, output ready);
endinterface

/* rtl/core/expression_token_syntax_checker.sv */
// ----------------------------------------------------------------------------
// Expression token syntax checker
// Judges a classified token stream against successor rules, tracks paren and
// call depth, and reports the first error with the last token.
// ----------------------------------------------------------------------------
// Takes one token beat per cycle, back to back, and produces one verdict beat
// for each token marked last. Each token passes through the input register,
// and the verdict for the last token is registered in the result register. A
// verdict that the receiver has not yet taken holds the token stream until it
// goes. Each token is judged once its two successors are known, so the block
// holds up to two tokens; the last token flushes them, which takes up to three
// chained window checks in the same cycle. That chain sets the clock period.
// No clearing pass after reset.
module expression_token_syntax_checker
   import etsc_pkg::*;
#(
   parameter int unsigned MAX_DEPTH  = 255,
   parameter int unsigned MAX_TOKENS = 1023
) (
   input  logic        clock,
   input  logic        reset,
   etsc_req_if.sink    req_chan,
   etsc_rsp_if.source  rsp_chan
);

   localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
   localparam int unsigned TW = $clog2(MAX_TOKENS + 1);
   localparam int unsigned PW = (TW > IndexWidth) ? TW : IndexWidth;

   typedef struct packed {
      logic                  in_call;
      logic [DW-1:0]         call_depth;
      logic [DW-1:0]         paren_depth;
      verdict_type           err;
      logic [IndexWidth-1:0] err_pos;
      logic [TW-1:0]         tok_cnt;
   } chk_state_type;

   function automatic logic [IndexWidth-1:0] low_index(input logic [TW-1:0] p);
      logic [PW-1:0] e;
      e = PW'(p);
      return e[IndexWidth-1:0];
   endfunction

   // One window check: token v with successors nx and nn.
   function automatic chk_state_type judge(input chk_state_type s,
                                           input tok_class_type v,
                                           input tok_class_type nx,
                                           input tok_class_type nn);
      chk_state_type o;
      verdict_type   err;
      logic          listed_v;
      logic          listed_nx;
      logic          ok_val;
      logic          ok_op;
      logic          ok_open;
      logic          ok_close;
      logic          ok_comma;
      o         = s;
      err       = VRD_OK;
      listed_v  = (v == CLS_UNARY) || (v == CLS_OPER);
      listed_nx = (nx == CLS_UNARY) || (nx == CLS_OPER);
      ok_val    = listed_nx || (nx == CLS_OPEN) || (nx == CLS_CLOSE) || (nx == CLS_NONE);
      ok_op     = (nx == CLS_VALUE) || (nx == CLS_OPEN) ||
                  ((nx == CLS_UNARY) && ((nn == CLS_VALUE) || (nn == CLS_OPEN)));
      ok_open   = (nx == CLS_VALUE) || (nx == CLS_UNARY) || (nx == CLS_CLOSE);
      ok_close  = listed_nx || (nx == CLS_NONE) || (nx == CLS_CLOSE);
      ok_comma  = (nx == CLS_VALUE) || (nx == CLS_UNARY) || (nx == CLS_OPEN);
      if (s.err == VRD_OK) begin
         if (s.tok_cnt < TW'(MAX_TOKENS)) begin
            o.tok_cnt = s.tok_cnt + TW'(1);
         end
         if ((s.tok_cnt == '0) &&
             !((v == CLS_VALUE) || (v == CLS_UNARY) || (v == CLS_OPEN))) begin
            err = VRD_START;
         end else if (!s.in_call) begin
            if ((v == CLS_VALUE) && !ok_val) err = VRD_OPER;
            else if (listed_v && !ok_op) err = VRD_VALUE;
            else if ((v == CLS_OPEN) && !ok_open) err = VRD_VALUE;
            else if ((v == CLS_CLOSE) && !ok_close) err = VRD_OPER;
         end else begin
            if ((v == CLS_OPEN) && !ok_open) err = VRD_VALUE;
            else if ((v == CLS_VALUE) && !(ok_val || (nx == CLS_COMMA))) err = VRD_OPER;
            else if (listed_v && !ok_op) err = VRD_VALUE;
            else if ((v == CLS_CLOSE) &&
                     !(ok_close || ((nx == CLS_COMMA) && (s.call_depth != DW'(1)))))
               err = VRD_OPER;
            else if ((v == CLS_COMMA) && !ok_comma) err = VRD_VALUE;
            if (err == VRD_OK) begin
               if (v == CLS_OPEN) begin
                  if (s.call_depth >= DW'(MAX_DEPTH)) err = VRD_DEPTH;
                  else o.call_depth = s.call_depth + DW'(1);
               end else if ((v == CLS_CLOSE) && (s.call_depth != '0)) begin
                  o.call_depth = s.call_depth - DW'(1);
                  // leave call mode when the outermost call closes
                  if (s.call_depth == DW'(1)) o.in_call = 1'b0;
               end
            end
         end
         if (err == VRD_OK) begin
            if ((v == CLS_VALUE) && (nx == CLS_OPEN)) o.in_call = 1'b1;
            if (v == CLS_OPEN) begin
               if (s.paren_depth >= DW'(MAX_DEPTH)) err = VRD_DEPTH;
               else o.paren_depth = s.paren_depth + DW'(1);
            end else if (v == CLS_CLOSE) begin
               if (s.paren_depth == '0) err = VRD_STRAY;
               else o.paren_depth = s.paren_depth - DW'(1);
            end
         end
         if (err != VRD_OK) begin
            o.err     = err;
            o.err_pos = low_index(s.tok_cnt);
         end
      end
      return o;
   endfunction

   // input register
   logic                  s0_valid_ff;
   logic [ClassWidth-1:0] s0_class_ff;
   logic                  s0_first_ff;
   logic                  s0_last_ff;
   logic                  s0_call_ff;

   // checker state
   chk_state_type         state_ff;
   chk_state_type         state_in;
   logic [ClassWidth-1:0] pend0_ff;
   logic [ClassWidth-1:0] pend0_in;
   logic [ClassWidth-1:0] pend1_ff;
   logic [ClassWidth-1:0] pend1_in;
   logic [1:0]            pend_cnt_ff;
   logic [1:0]            pend_cnt_in;

   // result register
   logic                  rsp_valid_ff;
   verdict_type           verdict_ff;
   verdict_type           verdict_in;
   logic [IndexWidth-1:0] index_ff;
   logic [IndexWidth-1:0] index_in;

   logic                  s0_adv;
   chk_state_type         base;
   chk_state_type         cleared;
   chk_state_type         s1;
   chk_state_type         s2;
   chk_state_type         s3;
   logic [1:0]            pend_n;
   tok_class_type         cur;
   tok_class_type         p0;
   tok_class_type         p1;
   tok_class_type         mid;
   logic [TW-1:0]         last_pos;

   assign s0_adv         = s0_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s0_valid_ff || s0_adv;

   always_comb begin
      cleared.in_call     = 1'b0;
      cleared.call_depth  = '0;
      cleared.paren_depth = '0;
      cleared.err         = VRD_OK;
      cleared.err_pos     = '0;
      cleared.tok_cnt     = '0;

      cur = tok_class_type'({1'b0, s0_class_ff});
      p0  = tok_class_type'({1'b0, pend0_ff});
      p1  = tok_class_type'({1'b0, pend1_ff});

      // a first token drops whatever was held
      if (s0_first_ff) begin
         base         = cleared;
         base.in_call = s0_call_ff;
         pend_n       = 2'd0;
      end else begin
         base   = state_ff;
         pend_n = pend_cnt_ff;
      end

      s1  = (pend_n == 2'd2) ? judge(base, p0, p1, cur) : base;
      mid = (pend_n == 2'd2) ? p1 : p0;
      s2  = (s0_last_ff && (pend_n != 2'd0)) ? judge(s1, mid, cur, CLS_NONE) : s1;
      s3  = s0_last_ff ? judge(s2, cur, CLS_NONE, CLS_NONE) : s2;

      last_pos   = (s3.tok_cnt == '0) ? '0 : s3.tok_cnt - TW'(1);
      verdict_in = s3.err;
      index_in   = s3.err_pos;
      if ((s3.err == VRD_OK) && (s3.paren_depth != '0)) begin
         verdict_in = VRD_MISSING;
         index_in   = low_index(last_pos);
      end
      if (verdict_in == VRD_OK) index_in = '0;

      // advance the lookahead window
      if (s0_last_ff) begin
         state_in    = cleared;
         pend0_in    = '0;
         pend1_in    = '0;
         pend_cnt_in = 2'd0;
      end else begin
         state_in = s3;
         case (pend_n)
            2'd0: begin
               pend0_in    = s0_class_ff;
               pend1_in    = '0;
               pend_cnt_in = 2'd1;
            end
            2'd1: begin
               pend0_in    = pend0_ff;
               pend1_in    = s0_class_ff;
               pend_cnt_in = 2'd2;
            end
            default: begin
               pend0_in    = pend1_ff;
               pend1_in    = s0_class_ff;
               pend_cnt_in = 2'd2;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s0_class_ff <= req_chan.token_class;
         s0_first_ff <= req_chan.first_token;
         s0_last_ff  <= req_chan.last_token;
         s0_call_ff  <= req_chan.call_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.in_call     <= 1'b0;
         state_ff.call_depth  <= '0;
         state_ff.paren_depth <= '0;
         state_ff.err         <= VRD_OK;
         state_ff.err_pos     <= '0;
         state_ff.tok_cnt     <= '0;
         pend0_ff             <= '0;
         pend1_ff             <= '0;
         pend_cnt_ff          <= 2'd0;
      end else if (s0_adv) begin
         state_ff    <= state_in;
         pend0_ff    <= pend0_in;
         pend1_ff    <= pend1_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s0_adv && s0_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv && s0_last_ff) begin
         verdict_ff <= verdict_in;
         index_ff   <= index_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.verdict     = verdict_ff;
   assign rsp_chan.error_index = index_ff;

`ifndef SYNTHESIS
   a_pend_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd3)
      else $error("lookahead window holds more than two tokens");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s0_adv && s0_last_ff) |=>
         (rsp_valid_ff && (pend_cnt_ff == 2'd0) && (state_ff.tok_cnt == '0)))
      else $error("state not cleared after verdict");

   a_ok_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (verdict_ff == VRD_OK)) |-> (index_ff == '0))
      else $error("ok verdict with nonzero index");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.paren_depth <= DW'(MAX_DEPTH)) && (state_ff.call_depth <= DW'(MAX_DEPTH)))
      else $error("depth counter beyond limit");
`endif

endmodule
